### hw/rtl/hkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hkr_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_SLOTS  = 6;

  typedef enum logic [2:0] {
    REQ_KEY_DOWN   = 3'd0,
    REQ_KEY_UP     = 3'd1,
    REQ_KEY_PRESS  = 3'd2,
    REQ_MOD_DOWN   = 3'd3,
    REQ_MOD_UP     = 3'd4,
    REQ_MOD_TOGGLE = 3'd5,
    REQ_MOD_PRESS  = 3'd6
  } req_type_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] code;
  } req_word_t;

  typedef struct packed {
    logic       report_sent;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic       last;
  } rpt_word_t;

  // Controller to datapath
  typedef struct packed {
    logic apply_first;   // apply the accepted request (down half of a press)
    logic apply_second;  // apply the up half of a pending press
    logic last;          // mark the word being loaded as final
  } hkr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_press;      // offered request is a press
  } hkr_status_t;

endpackage

`default_nettype wire

### hw/rtl/hkr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hkr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rpt_valid,
  input  wire logic                rpt_ready,
  input  wire hkr_pkg::hkr_status_t status,
  output hkr_pkg::hkr_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SECOND = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   rpt_valid_next;

  // Output register may be reloaded when empty or being drained this cycle.
  assign slot_free = !rpt_valid || rpt_ready;
  // Hold off requests while in reset.
  assign req_ready = !rst && (state == ST_IDLE) && slot_free;

  always_comb begin
    cmd.apply_first  = req_valid && req_ready;
    cmd.apply_second = (state == ST_SECOND) && slot_free;
    cmd.last         = cmd.apply_second || !status.in_press;
    state_next       = state;
    case (state)
      ST_IDLE: begin
        if (cmd.apply_first && status.in_press) begin
          state_next = ST_SECOND;
        end
      end
      ST_SECOND: begin
        if (cmd.apply_second) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.apply_first || cmd.apply_second) begin
      rpt_valid_next = 1'b1;
    end else if (rpt_ready) begin
      rpt_valid_next = 1'b0;
    end else begin
      rpt_valid_next = rpt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rpt_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rpt_valid <= rpt_valid_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hkr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hkr_dp #(
  parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hkr_pkg::req_word_t req,
  input  wire hkr_pkg::hkr_cmd_t  cmd,
  output hkr_pkg::hkr_status_t    status,
  output hkr_pkg::rpt_word_t      rpt
);

  logic [7:0] slots      [KEY_SLOTS];
  logic [7:0] slots_next [KEY_SLOTS];
  logic [7:0] rep_slots  [hkr_pkg::REPORT_SLOTS];
  logic [7:0] mask;
  logic [7:0] mask_next;
  logic [7:0] pend_code;
  logic       pend_mod;
  logic [2:0] op;
  logic [7:0] cur_code;
  logic [KEY_SLOTS-1:0] free_sel;
  logic [KEY_SLOTS-1:0] match_sel;
  logic       seen_free;
  logic       seen_match;
  logic       code_ok;
  logic       mod_hit;
  logic       do_down;
  logic       do_up;
  logic       sent;

  assign status.in_press = (req.req_type == hkr_pkg::REQ_KEY_PRESS) ||
                           (req.req_type == hkr_pkg::REQ_MOD_PRESS);

  always_comb begin
    if (cmd.apply_second) begin
      op       = pend_mod ? hkr_pkg::REQ_MOD_UP : hkr_pkg::REQ_KEY_UP;
      cur_code = pend_code;
    end else begin
      op       = req.req_type;
      cur_code = req.code;
    end

    // First empty slot and first slot holding the code, as one-hot selects
    seen_free  = 1'b0;
    seen_match = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      free_sel[i]  = (slots[i] == 8'd0) && !seen_free;
      match_sel[i] = (slots[i] == cur_code) && !seen_match;
      seen_free    = seen_free || (slots[i] == 8'd0);
      seen_match   = seen_match || (slots[i] == cur_code);
    end

    code_ok   = (cur_code != 8'd0);
    mod_hit   = ((mask & cur_code) != 8'd0);
    do_down   = 1'b0;
    do_up     = 1'b0;
    sent      = 1'b0;
    mask_next = mask;
    case (op)
      hkr_pkg::REQ_KEY_DOWN, hkr_pkg::REQ_KEY_PRESS: begin
        do_down = code_ok && (|free_sel);
      end
      hkr_pkg::REQ_KEY_UP: begin
        do_up = code_ok && (|match_sel);
      end
      hkr_pkg::REQ_MOD_DOWN, hkr_pkg::REQ_MOD_PRESS: begin
        mask_next = mask | cur_code;
        sent      = 1'b1;
      end
      hkr_pkg::REQ_MOD_UP: begin
        if (mod_hit) begin
          mask_next = mask & ~cur_code;
          sent      = 1'b1;
        end
      end
      hkr_pkg::REQ_MOD_TOGGLE: begin
        mask_next = mod_hit ? (mask & ~cur_code) : (mask | cur_code);
        sent      = 1'b1;
      end
      default: begin
      end
    endcase
    sent = sent || do_down || do_up;

    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (do_down && free_sel[i]) begin
        slots_next[i] = cur_code;
      end else if (do_up && match_sel[i]) begin
        slots_next[i] = 8'd0;
      end else begin
        slots_next[i] = slots[i];
      end
    end
  end

  // Slots past the report width are kept but not shown; missing ones read zero.
  for (genvar j = 0; j < hkr_pkg::REPORT_SLOTS; j++) begin : g_rep
    if (j < KEY_SLOTS) begin : g_have
      assign rep_slots[j] = slots_next[j];
    end else begin : g_none
      assign rep_slots[j] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 8'd0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= 8'd0;
      end
    end else if (cmd.apply_first || cmd.apply_second) begin
      mask <= mask_next;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= slots_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_first) begin
      pend_code <= req.code;
      pend_mod  <= (req.req_type == hkr_pkg::REQ_MOD_PRESS);
    end
    if (cmd.apply_first || cmd.apply_second) begin
      rpt.report_sent   <= sent;
      rpt.modifier_bits <= mask_next;
      rpt.key_slot_0    <= rep_slots[0];
      rpt.key_slot_1    <= rep_slots[1];
      rpt.key_slot_2    <= rep_slots[2];
      rpt.key_slot_3    <= rep_slots[3];
      rpt.key_slot_4    <= rep_slots[4];
      rpt.key_slot_5    <= rep_slots[5];
      rpt.last          <= cmd.last;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hid_keyboard_report_slots.sv
// Keeps a boot-protocol keyboard report (KEY_SLOTS key slots, six shown, plus
// an 8-bit modifier mask) and answers each request word with one report word,
// or two for the press operations (down half with last low, then up half with
// last high). The rate is set by the single output register, which holds
// one report word at a time and is refilled in the cycle it is drained, so
// one word leaves per cycle while the consumer keeps rpt_ready high. No new
// request is taken while the second half of a press is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_report_slots #(
  parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire hkr_pkg::req_word_t req,
  output logic                    rpt_valid,
  input  wire logic               rpt_ready,
  output hkr_pkg::rpt_word_t      rpt
);

  hkr_pkg::hkr_cmd_t    cmd;
  hkr_pkg::hkr_status_t status;

  // Sequence requests, press halves and the output handshake
  hkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold slots and mask, apply the operation, and register the report word
  hkr_dp #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rpt    (rpt)
  );

endmodule

`default_nettype wire

### hw/rtl/hkr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hkr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire hkr_pkg::req_word_t req,
  input wire logic               rpt_valid,
  input wire logic               rpt_ready,
  input wire hkr_pkg::rpt_word_t rpt
);

  logic req_take;
  logic req_press;

  assign req_take  = req_valid && req_ready;
  assign req_press = (req.req_type == hkr_pkg::REQ_KEY_PRESS) ||
                     (req.req_type == hkr_pkg::REQ_MOD_PRESS);

  // Hold a stalled report word
  a_rpt_hold: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
    else $error("report word changed while stalled");

  // Every accepted request shows its first word next cycle, last set unless press
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    req_take |=> rpt_valid && (rpt.last == !$past(req_press)))
    else $error("first word missing or last flag wrong");

  // Drop new requests while a press half is still owed
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt.last |-> !req_ready)
    else $error("request taken during a press");

  // Modifier down always sends and sets its bits
  a_mod_down: assert property (@(posedge clk) disable iff (rst)
    req_take && (req.req_type == hkr_pkg::REQ_MOD_DOWN) |=>
      rpt.report_sent && ((rpt.modifier_bits & $past(req.code)) == $past(req.code)))
    else $error("modifier down not applied");

endmodule

bind hid_keyboard_report_slots hkr_checker u_hkr_checker (.*);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS         = hkr_pkg::KEY_SLOTS_DEF;
  localparam int RANDOM_WORDS  = 450;
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES  = 8;     // one word per cycle while the receiver is open
  localparam int MAX_REPORTED  = 10;

  // Request code with no operation behind it.
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef enum {RX_OPEN, RX_HALF, RX_TIGHT} rx_mode_t;

  typedef struct {
    hkr_pkg::req_word_t word;
    bit                 pinned;    // expectation typed in below, not predicted
    hkr_pkg::rpt_word_t pin_rpt;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  hkr_pkg::req_word_t req = '0;
  logic               rpt_valid;
  logic               rpt_ready = 1'b0;
  hkr_pkg::rpt_word_t rpt;

  // Travel with the request word so the monitor sees them at acceptance.
  bit                 pin_on = 1'b0;
  hkr_pkg::rpt_word_t pin_word = '0;

  // Predictor state: the report as the block should hold it.
  logic [7:0] held_keys [SLOTS];
  logic [7:0] mod_mask;

  hkr_pkg::rpt_word_t report_q [$];
  stim_row_t          plan [$];
  int                 mismatch_count = 0;
  int                 checked_count = 0;
  int                 quiet_cycles = 0;

  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_phase = 0;

  always #10 clk = ~clk;

  hid_keyboard_report_slots dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt)
  );

  // ---------------------------------------------------------------------------
  // Report predictor
  // ---------------------------------------------------------------------------

  function automatic hkr_pkg::rpt_word_t report_of(bit sent, logic [7:0] mods,
                                                   logic [47:0] slots, bit fin);
    return {sent, mods, slots, fin};
  endfunction

  // Snapshot the predicted report; slots past the held count read empty.
  function automatic hkr_pkg::rpt_word_t current_report(bit sent, bit fin);
    logic [47:0] shown;
    shown = '0;
    for (int i = 0; i < hkr_pkg::REPORT_SLOTS; i++) begin
      if (i < SLOTS) shown[47 - 8 * i -: 8] = held_keys[i];
    end
    return report_of(sent, mod_mask, shown, fin);
  endfunction

  // Take the first empty slot; code zero marks an empty slot, so drop it.
  function automatic bit press_key(logic [7:0] c);
    if (c == 8'h00) return 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (held_keys[i] == 8'h00) begin
        held_keys[i] = c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Free the first slot that holds the code.
  function automatic bit release_key(logic [7:0] c);
    if (c == 8'h00) return 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (held_keys[i] == c) begin
        held_keys[i] = 8'h00;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Modifier down is sent even when no bit changes.
  function automatic bit set_mods(logic [7:0] c);
    mod_mask = mod_mask | c;
    return 1'b1;
  endfunction

  // Modifier up is dropped when none of the named bits is set.
  function automatic bit clear_mods(logic [7:0] c);
    if ((mod_mask & c) == 8'h00) return 1'b0;
    mod_mask = mod_mask & ~c;
    return 1'b1;
  endfunction

  // Advance the predicted report by one request and queue the words it sends.
  // A press queues its down half first, then the up half runs regardless.
  task automatic predict_reports(hkr_pkg::req_word_t w, bit pinned,
                                 hkr_pkg::rpt_word_t pin);
    bit took;
    case (w.req_type)
      hkr_pkg::REQ_KEY_DOWN:   took = press_key(w.code);
      hkr_pkg::REQ_KEY_UP:     took = release_key(w.code);
      hkr_pkg::REQ_KEY_PRESS: begin
        took = press_key(w.code);
        report_q.push_back(current_report(took, 1'b0));
        took = release_key(w.code);
      end
      hkr_pkg::REQ_MOD_DOWN:   took = set_mods(w.code);
      hkr_pkg::REQ_MOD_UP:     took = clear_mods(w.code);
      hkr_pkg::REQ_MOD_TOGGLE: took = ((mod_mask & w.code) != 8'h00) ? clear_mods(w.code)
                                                                      : set_mods(w.code);
      hkr_pkg::REQ_MOD_PRESS: begin
        took = set_mods(w.code);
        report_q.push_back(current_report(took, 1'b0));
        took = clear_mods(w.code);
      end
      default:        took = 1'b0;
    endcase
    report_q.push_back(pinned ? pin : current_report(took, 1'b1));
  endtask

  function automatic string fmt_report(hkr_pkg::rpt_word_t r);
    return $sformatf("sent=%0b mods=%02h keys=%02h %02h %02h %02h %02h %02h last=%0b",
                     r.report_sent, r.modifier_bits, r.key_slot_0, r.key_slot_1,
                     r.key_slot_2, r.key_slot_3, r.key_slot_4, r.key_slot_5, r.last);
  endfunction

  function automatic bit same_report(hkr_pkg::rpt_word_t e, hkr_pkg::rpt_word_t g);
    return (g.report_sent   === e.report_sent)   &&
           (g.modifier_bits === e.modifier_bits) &&
           (g.key_slot_0    === e.key_slot_0)    &&
           (g.key_slot_1    === e.key_slot_1)    &&
           (g.key_slot_2    === e.key_slot_2)    &&
           (g.key_slot_3    === e.key_slot_3)    &&
           (g.key_slot_4    === e.key_slot_4)    &&
           (g.key_slot_5    === e.key_slot_5)    &&
           (g.last          === e.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check the report word
  // first, then predict from the request word taken at the same edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    hkr_pkg::rpt_word_t want;
    if (!rst) begin
      if (rpt_valid && rpt_ready) begin
        checked_count++;
        if (report_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("report word %0d arrived with none expected: %s",
                     checked_count, fmt_report(rpt));
        end else begin
          want = report_q.pop_front();
          if (!same_report(want, rpt)) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
              $display("report word %0d differs", checked_count);
              $display("  expected %s", fmt_report(want));
              $display("  actual   %s", fmt_report(rpt));
            end
          end
        end
      end

      if (req_valid && req_ready)
        predict_reports(req, pin_on, pin_word);

      // Watchdog: give up once neither channel has moved for too long.
      if ((req_valid && req_ready) || (rpt_valid && rpt_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d report words still due",
                 QUIET_LIMIT, report_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own. Switch between fully open,
  // coin-flip and mostly-stalled stretches of random length.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(0, 2));
      rx_phase <= $urandom_range(16, 80);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      RX_OPEN:  rpt_ready <= 1'b1;
      RX_HALF:  rpt_ready <= 1'($urandom_range(0, 1));
      default:  rpt_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  task automatic plan_row(logic [2:0] op, logic [7:0] c);
    stim_row_t row;
    row.word    = '{req_type: op, code: c};
    row.pinned  = 1'b0;
    row.pin_rpt = '0;
    plan.push_back(row);
  endtask

  task automatic plan_pin(logic [2:0] op, logic [7:0] c, hkr_pkg::rpt_word_t r);
    stim_row_t row;
    row.word    = '{req_type: op, code: c};
    row.pinned  = 1'b1;
    row.pin_rpt = r;
    plan.push_back(row);
  endtask

  // Present one request word at the falling edge and hold it until taken.
  // Return at the falling edge after acceptance.
  task automatic push_word(hkr_pkg::req_word_t w, bit pinned, hkr_pkg::rpt_word_t pin);
    req       <= w;
    pin_on    <= pinned;
    pin_word  <= pin;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  initial begin
    hkr_pkg::req_word_t w;
    stim_row_t          row;
    int                 burst_left;
    int                 gap;
    int                 pick;
    int                 total;

    for (int i = 0; i < SLOTS; i++) held_keys[i] = 8'h00;
    mod_mask = 8'h00;

    // Directed part, starting from the empty report.
    plan_pin(hkr_pkg::REQ_KEY_DOWN, 8'h00,
             report_of(1'b0, 8'h00, 48'h0, 1'b1));  // zero is no key
    plan_pin(hkr_pkg::REQ_KEY_UP,   8'h04,
             report_of(1'b0, 8'h00, 48'h0, 1'b1));  // key not held
    plan_pin(hkr_pkg::REQ_MOD_UP,   8'hFF,
             report_of(1'b0, 8'h00, 48'h0, 1'b1));  // no bit set
    plan_pin(REQ_UNUSED,            8'hA5,
             report_of(1'b0, 8'h00, 48'h0, 1'b1));  // no such operation
    plan_pin(hkr_pkg::REQ_KEY_DOWN, 8'hFF,
             report_of(1'b1, 8'h00, 48'hFF00_0000_0000, 1'b1));
    plan_pin(hkr_pkg::REQ_KEY_DOWN, 8'h01,
             report_of(1'b1, 8'h00, 48'hFF01_0000_0000, 1'b1));
    plan_row(hkr_pkg::REQ_KEY_DOWN, 8'h04);
    plan_row(hkr_pkg::REQ_KEY_DOWN, 8'h05);
    plan_row(hkr_pkg::REQ_KEY_DOWN, 8'h06);
    plan_row(hkr_pkg::REQ_KEY_DOWN, 8'h07);
    // Report full: the next key is dropped.
    plan_pin(hkr_pkg::REQ_KEY_DOWN, 8'h08,
             report_of(1'b0, 8'h00, 48'hFF01_0405_0607, 1'b1));
    plan_row(hkr_pkg::REQ_KEY_UP,     8'h05);  // open a hole in the middle
    plan_row(hkr_pkg::REQ_KEY_DOWN,   8'h09);  // and refill it
    plan_row(hkr_pkg::REQ_MOD_DOWN,   8'h00);  // sent although nothing changes
    plan_row(hkr_pkg::REQ_MOD_DOWN,   8'h81);
    plan_row(hkr_pkg::REQ_MOD_TOGGLE, 8'h01);  // set, so toggle releases
    plan_row(hkr_pkg::REQ_MOD_TOGGLE, 8'h02);  // clear, so toggle presses
    plan_row(hkr_pkg::REQ_MOD_UP,     8'h40);  // not set: dropped
    plan_row(hkr_pkg::REQ_MOD_UP,     8'hFF);
    plan_row(hkr_pkg::REQ_KEY_UP,     8'hFF);
    plan_row(hkr_pkg::REQ_KEY_PRESS,  8'h2A);  // both halves take effect
    plan_row(hkr_pkg::REQ_KEY_PRESS,  8'h00);  // both halves dropped
    plan_row(hkr_pkg::REQ_KEY_DOWN,   8'h2A);  // full again
    plan_row(hkr_pkg::REQ_KEY_PRESS,  8'h0B);  // full and not held: both dropped
    plan_row(hkr_pkg::REQ_KEY_PRESS,  8'h06);  // down dropped, up still frees the key
    plan_row(hkr_pkg::REQ_MOD_PRESS,  8'hFF);
    plan_row(hkr_pkg::REQ_MOD_PRESS,  8'h00);  // down sent, up dropped

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    total      = plan.size() + RANDOM_WORDS;
    burst_left = 0;
    for (int n = 0; n < total; n++) begin
      if (n < plan.size()) begin
        row = plan[n];
      end else begin
        // Draw keys mostly from a small pool so key up finds held keys and
        // the report fills up; draw the full byte range the rest of the time.
        pick = $urandom_range(0, 99);
        if      (pick < 25) w.req_type = hkr_pkg::REQ_KEY_DOWN;
        else if (pick < 45) w.req_type = hkr_pkg::REQ_KEY_UP;
        else if (pick < 55) w.req_type = hkr_pkg::REQ_KEY_PRESS;
        else if (pick < 67) w.req_type = hkr_pkg::REQ_MOD_DOWN;
        else if (pick < 77) w.req_type = hkr_pkg::REQ_MOD_UP;
        else if (pick < 87) w.req_type = hkr_pkg::REQ_MOD_TOGGLE;
        else if (pick < 95) w.req_type = hkr_pkg::REQ_MOD_PRESS;
        else                w.req_type = REQ_UNUSED;
        if (w.req_type inside {hkr_pkg::REQ_KEY_DOWN, hkr_pkg::REQ_KEY_UP,
                               hkr_pkg::REQ_KEY_PRESS}) begin
          w.code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(1, 12));
        end else begin
          w.code = ($urandom_range(0, 1) == 0) ? 8'(1 << $urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
        end
        row.word    = w;
        row.pinned  = 1'b0;
        row.pin_rpt = '0;
      end

      // Work in bursts; drop valid for a random gap between them.
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      push_word(row.word, row.pinned, row.pin_rpt);
      burst_left--;
    end
    req_valid <= 1'b0;

    // Drain: wait for every expected word, then watch for strays.
    while (report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
